### sv/dtw_pkg.sv
// ----------------------------------------------------------------------------
// dtw_pkg: shared types and constants for the DTW distance engine
// Sizes of the sample stores, cost words and square-root unit, the item
// structs of both channels and the controller/datapath command and status.
// ----------------------------------------------------------------------------
package dtw_pkg;

   // storage sizing
   localparam int MAX_LEN  = 256;
   localparam int IDX_W    = $clog2(MAX_LEN);
   localparam int LEN_W    = $clog2(MAX_LEN + 1);
   localparam int SAMPLE_W = 16;
   localparam int DIFF_W   = 16;

   // cost word: path of at most 2*MAX_LEN cells, plus headroom for the
   // unreachable marker
   localparam int COST_W   = DIFF_W + 1 + $clog2(2 * MAX_LEN);

   // result fields
   localparam int TOTAL_W  = 25;
   localparam int DIST_W   = 17;
   localparam logic [TOTAL_W-1:0] COST_MAX = {TOTAL_W{1'b1}};
   localparam logic [DIST_W-1:0]  DIST_MAX = {DIST_W{1'b1}};

   // digit-by-digit square root of cost * 256
   localparam int ROOT_W   = (COST_W + 8 + 1) / 2;
   localparam int RAD_W    = 2 * ROOT_W;
   localparam int REM_W    = ROOT_W + 2;
   localparam int ITER_W   = $clog2(ROOT_W);

   typedef struct packed {
      logic                       series_sel;
      logic signed [SAMPLE_W-1:0] sample;
      logic                       last;
   } req_type;

   typedef struct packed {
      logic [TOTAL_W-1:0] total_cost;
      logic [DIST_W-1:0]  distance;
      logic               status;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_ROW,
      ST_FILL,
      ST_RINIT,
      ST_ROOT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;    // accept an item into the stores
      logic row;     // open a table row
      logic fill;    // compute one table entry
      logic rinit;   // load the square-root unit
      logic rstep;   // one square-root digit
      logic emit;    // register the result and clear the pair
   } cmd_type;

   typedef struct packed {
      logic ends_pair;  // item on the request port ends series 1
      logic len0_zero;  // series 0 is empty
      logic col_last;   // current column is the last one
      logic row_last;   // current row is the last one
      logic root_last;  // final square-root digit
   } stat_type;

endpackage

### sv/dtw_ram.sv
// ----------------------------------------------------------------------------
// dtw_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module dtw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/dtw_ctrl.sv
// ----------------------------------------------------------------------------
// dtw_ctrl: sequencer of the DTW distance engine
// Loads samples, walks the table row by row, runs the square root, emits.
// ----------------------------------------------------------------------------
module dtw_ctrl import dtw_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  stat_type stat,
   output cmd_type  cmd,
   output logic     busy,
   output logic     rsp_valid
);

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (start && stat.ends_pair) begin
               state_in = stat.len0_zero ? ST_EMIT : ST_ROW;
            end
         end
         ST_ROW: begin
            state_in = ST_FILL;
         end
         ST_FILL: begin
            if (stat.col_last) begin
               state_in = stat.row_last ? ST_RINIT : ST_ROW;
            end
         end
         ST_RINIT: begin
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (stat.root_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            state_in = ST_LOAD;
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         ST_LOAD: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_ROW:   cmd.row   = 1'b1;
         ST_FILL:  cmd.fill  = 1'b1;
         ST_RINIT: cmd.rinit = 1'b1;
         ST_ROOT:  cmd.rstep = 1'b1;
         ST_EMIT:  cmd.emit  = 1'b1;
         default:  cmd       = '0;
      endcase
   end

   // strobe the result in the cycle after emit
   assign valid_in = cmd.emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff;

endmodule

### sv/dtw_datapath.sv
// ----------------------------------------------------------------------------
// dtw_datapath: stores, table entry unit and square root of the DTW engine
// Holds both series and one table row in RAM, computes one entry a cycle
// while filling a row and takes the root of the final cost one digit a cycle.
// ----------------------------------------------------------------------------
module dtw_datapath import dtw_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cmd_type  cmd,
   input  req_type  req,
   output stat_type stat,
   output rsp_type  rsp
);

   localparam logic [COST_W-1:0] INF = {COST_W{1'b1}};

   logic [LEN_W-1:0]  len0_ff, len0_in;
   logic [LEN_W-1:0]  len1_ff, len1_in;
   logic              first_done_ff, first_done_in;
   logic              err_ff, err_in;
   logic [IDX_W-1:0]  row_ff, row_in;
   logic [IDX_W-1:0]  col_ff, col_in;
   logic [COST_W-1:0] left_ff, left_in;
   logic [COST_W-1:0] diag_ff, diag_in;
   logic [RAD_W-1:0]  rad_ff, rad_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   rsp_type           rsp_ff, rsp_in;

   logic                      wr0_en, wr1_en;
   logic [IDX_W-1:0]          rd_col;
   logic [SAMPLE_W-1:0]       a_rd, b_rd;
   logic [COST_W-1:0]         up_rd;
   logic signed [SAMPLE_W:0]  diff;
   logic [DIFF_W-1:0]         absd;
   logic                      first_row, first_col;
   logic [COST_W-1:0]         up, left, diag, best, entry;
   logic [REM_W-1:0]          rem_sh, trial;
   logic                      take;
   logic [COST_W+TOTAL_W-1:0] total_ext;
   logic [ROOT_W+DIST_W-1:0]  root_ext;

   // store writes
   assign wr0_en = cmd.load && !req.series_sel && !first_done_ff &&
                   (len0_ff < LEN_W'(MAX_LEN));
   assign wr1_en = cmd.load && req.series_sel && (len1_ff < LEN_W'(MAX_LEN));

   // read one column ahead of the entry being computed
   assign rd_col = cmd.fill ? (col_ff + IDX_W'(1)) : '0;

   dtw_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_LEN)) u_first_store (
      .clock   (clock),
      .wr_en   (wr0_en),
      .wr_addr (len0_ff[IDX_W-1:0]),
      .wr_data (req.sample),
      .rd_addr (row_ff),
      .rd_data (a_rd)
   );

   dtw_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_LEN)) u_second_store (
      .clock   (clock),
      .wr_en   (wr1_en),
      .wr_addr (len1_ff[IDX_W-1:0]),
      .wr_data (req.sample),
      .rd_addr (rd_col),
      .rd_data (b_rd)
   );

   // cost row: address k holds table column k+1, column 0 is implied
   dtw_ram #(.WIDTH(COST_W), .DEPTH(MAX_LEN)) u_cost_row (
      .clock   (clock),
      .wr_en   (cmd.fill),
      .wr_addr (col_ff),
      .wr_data (entry),
      .rd_addr (rd_col),
      .rd_data (up_rd)
   );

   // table entry: absolute difference plus least neighbour
   assign diff      = {a_rd[SAMPLE_W-1], a_rd} - {b_rd[SAMPLE_W-1], b_rd};
   assign absd      = diff[SAMPLE_W] ? DIFF_W'(-diff) : diff[DIFF_W-1:0];
   assign first_row = (row_ff == '0);
   assign first_col = (col_ff == '0);
   assign up        = first_row ? INF : up_rd;
   assign left      = first_col ? INF : left_ff;
   assign diag      = first_col ? (first_row ? '0 : INF) : diag_ff;

   always_comb begin
      best = up;
      if (left < best) begin
         best = left;
      end
      if (diag < best) begin
         best = diag;
      end
   end

   assign entry = COST_W'(absd) + best;

   // square-root digit
   assign rem_sh = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1 -: 2]};
   assign trial  = {root_ff, 2'b01};
   assign take   = (rem_sh >= trial);

   // result saturation
   assign total_ext = (COST_W+TOTAL_W)'(left_ff);
   assign root_ext  = (ROOT_W+DIST_W)'(root_ff);

   // status to the controller
   assign stat.ends_pair = req.series_sel && req.last;
   assign stat.len0_zero = (len0_ff == '0);
   assign stat.col_last  = ((LEN_W'(col_ff) + LEN_W'(1)) == len1_ff);
   assign stat.row_last  = ((LEN_W'(row_ff) + LEN_W'(1)) == len0_ff);
   assign stat.root_last = (iter_ff == ITER_W'(ROOT_W - 1));

   // next values
   always_comb begin
      len0_in       = len0_ff;
      len1_in       = len1_ff;
      first_done_in = first_done_ff;
      err_in        = err_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      left_in       = left_ff;
      diag_in       = diag_ff;
      rad_in        = rad_ff;
      rem_in        = rem_ff;
      root_in       = root_ff;
      iter_in       = iter_ff;
      rsp_in        = rsp_ff;

      // load an item; drop it when its store is full or, for series 0, after its end
      if (cmd.load) begin
         if (!req.series_sel) begin
            if (!first_done_ff) begin
               if (wr0_en) begin
                  len0_in = len0_ff + LEN_W'(1);
               end
               if (req.last) begin
                  first_done_in = 1'b1;
               end
            end
         end else begin
            if (wr1_en) begin
               len1_in = len1_ff + LEN_W'(1);
            end
            if (req.last) begin
               err_in = (len0_ff == '0);
               row_in = '0;
            end
         end
      end

      // advance across the table
      if (cmd.row) begin
         col_in = '0;
      end
      if (cmd.fill) begin
         col_in  = col_ff + IDX_W'(1);
         left_in = entry;
         diag_in = up;
         if (stat.col_last) begin
            row_in = row_ff + IDX_W'(1);
         end
      end

      // square root of cost * 256
      if (cmd.rinit) begin
         rad_in  = RAD_W'({left_ff, 8'b0});
         rem_in  = '0;
         root_in = '0;
         iter_in = '0;
      end
      if (cmd.rstep) begin
         rad_in  = rad_ff << 2;
         rem_in  = take ? (rem_sh - trial) : rem_sh;
         root_in = {root_ff[ROOT_W-2:0], take};
         iter_in = iter_ff + ITER_W'(1);
      end

      // register the result and clear the pair
      if (cmd.emit) begin
         if (err_ff) begin
            rsp_in.total_cost = '0;
            rsp_in.distance   = '0;
            rsp_in.status     = 1'b1;
         end else begin
            rsp_in.total_cost = (total_ext > (COST_W+TOTAL_W)'(COST_MAX)) ?
                                COST_MAX : TOTAL_W'(left_ff);
            rsp_in.distance   = (root_ext > (ROOT_W+DIST_W)'(DIST_MAX)) ?
                                DIST_MAX : DIST_W'(root_ff);
            rsp_in.status     = 1'b0;
         end
         len0_in       = '0;
         len1_in       = '0;
         first_done_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         len0_ff       <= '0;
         len1_ff       <= '0;
         first_done_ff <= 1'b0;
         err_ff        <= 1'b0;
      end else begin
         len0_ff       <= len0_in;
         len1_ff       <= len1_in;
         first_done_ff <= first_done_in;
         err_ff        <= err_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      row_ff  <= row_in;
      col_ff  <= col_in;
      left_ff <= left_in;
      diag_ff <= diag_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      iter_ff <= iter_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp = rsp_ff;

endmodule

### sv/dtw_distance_engine.sv
// ----------------------------------------------------------------------------
// dtw_distance_engine: dynamic time warping distance of two sample series
// Samples load while start is high and busy low. The item ending series 1
// raises busy for the table walk, a row per series-0 sample and an entry a
// cycle per series-1 sample, then the square root of ROOT_W digits (17 at the
// default size), one digit a cycle; if series 0 is empty, only the emit state.
// The result strobes in the first cycle with busy low; it cannot be stalled.
// Synchronous reset empties both series; no clearing pass is needed.
// ----------------------------------------------------------------------------
module dtw_distance_engine import dtw_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   cmd_type  cmd;
   stat_type stat;

   // sequencer
   dtw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // stores, table unit and square root
   dtw_datapath u_datapath (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .req   (req_data),
      .stat  (stat),
      .rsp   (rsp_data)
   );

endmodule

### sv/dtw_checker.sv
// ----------------------------------------------------------------------------
// dtw_checker: port-level checks of the DTW distance engine
// Watches the handshake and result ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module dtw_checker import dtw_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   // a result strobes for one cycle only
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // an item that does not end series 1 never stalls the port
   a_load_no_stall: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !(req_data.series_sel && req_data.last)) |=> !busy)
      else $error("busy after a plain load item");

   // the item ending series 1 starts the computation
   a_end_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.series_sel && req_data.last) |=> busy)
      else $error("no busy after the item ending series 1");

   // a result appears once the engine is free again
   a_result_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!busy && $past(busy)))
      else $error("result shown while busy or without a computation");

   // an error result carries no cost
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status) |->
         (rsp_data.total_cost == '0 && rsp_data.distance == '0))
      else $error("error result with nonzero cost");

endmodule

bind dtw_distance_engine dtw_checker u_checker (.*);

### bench/tb_dtw_distance_engine.sv
// ----------------------------------------------------------------------------
// tb_dtw_distance_engine: self-checking bench for the DTW distance engine
// A table of directed items covers the sample extremes, the empty first series,
// series 1 arriving before series 0 ends and series 0 items after its end.
// Random pairs follow. Most are well formed and small, a few broken or noisy,
// and at most two run near or past the sample store size. The sender idles at
// random in several phases. Every result is checked field by field against a
// directed golden value or a warping cost predictor fed every accepted item.
// ----------------------------------------------------------------------------
module tb_dtw_distance_engine import dtw_pkg::*; ();

   localparam logic SERIES_FIRST  = 1'b0;
   localparam logic SERIES_SECOND = 1'b1;
   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_EMPTY  = 1'b1;
   localparam int   RANDOM_ITEMS  = 2000;
   localparam int   PHASE_ITEMS   = 500;
   localparam int   LONG_PAIRS    = 2;
   localparam int   CYCLE_LIMIT   = 3_000_000;
   localparam logic [63:0] UNREACHABLE = '1;

   typedef struct {
      req_type item;
      bit      has_golden;
      rsp_type golden;
   } plan_row_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   // predictor state: samples stored for the current pair
   logic signed [SAMPLE_W-1:0] first_samples[$];
   logic signed [SAMPLE_W-1:0] second_samples[$];
   bit                         first_closed;

   rsp_type      awaited_distances[$];
   plan_row_type directed_plan[$];
   int           error_count;
   int           cycle_count;
   int           idle_pct;
   int           items_sent;
   int           long_pairs;

   dtw_distance_engine dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // minimal accumulated warping cost over the stored samples
   function automatic logic [63:0] warp_cost();
      logic [63:0] cost_line [0:MAX_LEN];
      logic [63:0] above;
      logic [63:0] corner;
      logic [63:0] best;
      int          diff;
      int          n;
      int          m;
      n = first_samples.size();
      m = second_samples.size();
      cost_line[0] = '0;
      for (int j = 1; j <= m; j++)
         cost_line[j] = UNREACHABLE;
      for (int i = 1; i <= n; i++) begin
         corner = cost_line[0];
         cost_line[0] = UNREACHABLE;
         for (int j = 1; j <= m; j++) begin
            diff = int'(first_samples[i-1]) - int'(second_samples[j-1]);
            if (diff < 0) begin
               diff = -diff;
            end
            above = cost_line[j];
            best = above;
            if (cost_line[j-1] < best) begin
               best = cost_line[j-1];
            end
            if (corner < best) begin
               best = corner;
            end
            corner = above;
            cost_line[j] = 64'(diff) + best;
         end
      end
      return cost_line[m];
   endfunction

   // floor of the square root, one bit at a time from the top
   function automatic logic [63:0] square_root(input logic [63:0] radicand);
      logic [63:0] root;
      logic [63:0] trial;
      root = '0;
      for (int b = 20; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= radicand) begin
            root = trial;
         end
      end
      return root;
   endfunction

   // advance the predictor by one accepted item; 1 when it ends a pair
   function automatic bit absorb_sample(input req_type item, output rsp_type res);
      logic [63:0] total;
      logic [63:0] root;
      res = '0;
      if (item.series_sel == SERIES_FIRST) begin
         if (!first_closed) begin
            if (first_samples.size() < MAX_LEN) begin
               first_samples.push_back(item.sample);
            end
            if (item.last) begin
               first_closed = 1'b1;
            end
         end
         return 1'b0;
      end
      if (second_samples.size() < MAX_LEN) begin
         second_samples.push_back(item.sample);
      end
      if (!item.last) begin
         return 1'b0;
      end
      if (first_samples.size() == 0) begin
         res.status = STATUS_EMPTY;
      end else begin
         total = warp_cost();
         root = square_root(total << 8);
         res.total_cost = (total > 64'(COST_MAX)) ? COST_MAX : total[TOTAL_W-1:0];
         res.distance = (root > 64'(DIST_MAX)) ? DIST_MAX : root[DIST_W-1:0];
         res.status = STATUS_OK;
      end
      first_samples.delete();
      second_samples.delete();
      first_closed = 1'b0;
      return 1'b1;
   endfunction

   function automatic logic [SAMPLE_W-1:0] random_sample();
      logic [31:0] r;
      r = $urandom;
      case (r[18:16])
         3'd0: return 16'h8000;
         3'd1: return 16'h7FFF;
         3'd2: return {{8{r[7]}}, r[7:0]};
         3'd3: return 16'h0000;
         default: return r[15:0];
      endcase
   endfunction

   function automatic req_type make_item(input logic sel, input logic [SAMPLE_W-1:0] smp,
                                         input logic lst);
      req_type item;
      item.series_sel = sel;
      item.sample = smp;
      item.last = lst;
      return item;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH %s: got %0d expected %0d (cycle %0d)", what, got, want,
               cycle_count);
      error_count++;
   endtask

   task automatic add_row(input logic sel, input logic [SAMPLE_W-1:0] smp, input logic lst,
                          input bit golden, input int total, input int root_q8,
                          input logic status);
      plan_row_type row;
      row.item = make_item(sel, smp, lst);
      row.has_golden = golden;
      row.golden.total_cost = total[TOTAL_W-1:0];
      row.golden.distance = root_q8[DIST_W-1:0];
      row.golden.status = status;
      directed_plan.push_back(row);
   endtask

   // offer one item, idling at random first, and hold it until accepted
   task automatic drive_item(input req_type item, input bit use_golden,
                             input rsp_type golden);
      rsp_type predicted;
      logic [31:0] junk;
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         junk = $urandom;
         start <= 1'b0;
         req_data <= junk[$bits(req_type)-1:0];
         @(negedge clock);
      end
      start <= 1'b1;
      req_data <= item;
      do
         @(posedge clock);
      while (busy);
      if (absorb_sample(item, predicted)) begin
         awaited_distances.push_back(use_golden ? golden : predicted);
      end
   endtask

   // build one random pair of series and send it
   task automatic send_pair();
      req_type first_part[$];
      req_type second_part[$];
      req_type pair_items[$];
      req_type closing;
      int      kind;
      int      n;
      int      m;
      bit      is_long;
      bit      broken;
      bit      noisy;
      bit      mixed;
      kind = $urandom_range(99);
      is_long = (kind < 2) && (long_pairs < LONG_PAIRS);
      broken = (kind >= 8) && (kind < 16);
      noisy = (kind >= 16) && (kind < 26);
      mixed = !is_long && ((kind >= 26 && kind < 40) || (noisy && $urandom_range(1) == 1));
      if (is_long) begin
         long_pairs++;
         n = $urandom_range(MAX_LEN - 6, MAX_LEN + 6);
         m = $urandom_range(MAX_LEN - 6, MAX_LEN + 6);
      end else begin
         n = ($urandom_range(9) == 0) ? $urandom_range(9, 32) : $urandom_range(1, 8);
         m = ($urandom_range(9) == 0) ? $urandom_range(9, 32) : $urandom_range(1, 8);
         if (kind < 8) begin
            n = 0;
         end
      end
      for (int i = 0; i < n; i++)
         first_part.push_back(make_item(SERIES_FIRST, random_sample(),
                                        (i == n - 1) && !broken));
      // series 0 items after its end are ignored by the block
      if (noisy && n > 0) begin
         repeat ($urandom_range(1, 3))
            first_part.push_back(make_item(SERIES_FIRST, random_sample(),
                                           $urandom_range(1) == 1));
      end
      for (int j = 0; j < m; j++)
         second_part.push_back(make_item(SERIES_SECOND, random_sample(), j == m - 1));
      closing = second_part.pop_back();
      while (first_part.size() > 0 || second_part.size() > 0) begin
         if (second_part.size() == 0 ||
             (first_part.size() > 0 && (!mixed || $urandom_range(1) == 1))) begin
            pair_items.push_back(first_part.pop_front());
         end else begin
            pair_items.push_back(second_part.pop_front());
         end
      end
      pair_items.push_back(closing);
      foreach (pair_items[k])
         drive_item(pair_items[k], 1'b0, '0);
      items_sent += pair_items.size();
   endtask

   // check each result against the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (awaited_distances.size() == 0) begin
            report_mismatch("unexpected result, total_cost", 32'(rsp_data.total_cost), 0);
         end else begin
            want = awaited_distances.pop_front();
            if (rsp_data.total_cost !== want.total_cost)
               report_mismatch("total_cost", 32'(rsp_data.total_cost), 32'(want.total_cost));
            if (rsp_data.distance !== want.distance)
               report_mismatch("distance", 32'(rsp_data.distance), 32'(want.distance));
            if (rsp_data.status !== want.status)
               report_mismatch("status", 32'(rsp_data.status), 32'(want.status));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      error_count = 0;
      cycle_count = 0;
      idle_pct = 0;
      items_sent = 0;
      long_pairs = 0;
      first_closed = 1'b0;

      // directed table: extremes, empty first series and ordering cases
      add_row(SERIES_SECOND, 16'h1234, 1'b1, 1'b1, 0, 0, STATUS_EMPTY);
      add_row(SERIES_FIRST,  16'h8000, 1'b1, 1'b0, 0, 0, STATUS_OK);
      add_row(SERIES_SECOND, 16'h7FFF, 1'b1, 1'b1, 65535, 4095, STATUS_OK);
      add_row(SERIES_FIRST,  16'h0100, 1'b1, 1'b0, 0, 0, STATUS_OK);
      add_row(SERIES_SECOND, 16'h0100, 1'b1, 1'b1, 0, 0, STATUS_OK);
      add_row(SERIES_FIRST,  16'hFFFF, 1'b0, 1'b0, 0, 0, STATUS_OK);
      add_row(SERIES_FIRST,  16'h7FFF, 1'b0, 1'b0, 0, 0, STATUS_OK);
      add_row(SERIES_FIRST,  16'h8000, 1'b1, 1'b0, 0, 0, STATUS_OK);
      add_row(SERIES_FIRST,  16'h0005, 1'b1, 1'b0, 0, 0, STATUS_OK);
      add_row(SERIES_FIRST,  16'h7FFF, 1'b0, 1'b0, 0, 0, STATUS_OK);
      add_row(SERIES_SECOND, 16'h0000, 1'b0, 1'b0, 0, 0, STATUS_OK);
      add_row(SERIES_SECOND, 16'hFFFF, 1'b0, 1'b0, 0, 0, STATUS_OK);
      add_row(SERIES_SECOND, 16'h4000, 1'b1, 1'b0, 0, 0, STATUS_OK);
      add_row(SERIES_FIRST,  16'h0010, 1'b0, 1'b0, 0, 0, STATUS_OK);
      add_row(SERIES_SECOND, 16'h0020, 1'b0, 1'b0, 0, 0, STATUS_OK);
      add_row(SERIES_FIRST,  16'h0030, 1'b0, 1'b0, 0, 0, STATUS_OK);
      add_row(SERIES_SECOND, 16'hFFF0, 1'b1, 1'b0, 0, 0, STATUS_OK);
      add_row(SERIES_FIRST,  16'h00FF, 1'b0, 1'b0, 0, 0, STATUS_OK);
      add_row(SERIES_SECOND, 16'h8000, 1'b1, 1'b0, 0, 0, STATUS_OK);
      add_row(SERIES_SECOND, 16'h5555, 1'b0, 1'b0, 0, 0, STATUS_OK);
      add_row(SERIES_SECOND, 16'hAAAA, 1'b1, 1'b1, 0, 0, STATUS_EMPTY);

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_plan[r])
         drive_item(directed_plan[r].item, directed_plan[r].has_golden,
                    directed_plan[r].golden);

      // random pairs; the sender idling changes with each phase
      while (items_sent < RANDOM_ITEMS) begin
         case (items_sent / PHASE_ITEMS)
            0: idle_pct = 0;
            1: idle_pct = 69;
            2: idle_pct = 0;
            default: idle_pct = 23;
         endcase
         send_pair();
      end

      // drop start, drain the outstanding results, then let the block settle
      @(negedge clock);
      start <= 1'b0;
      while (awaited_distances.size() > 0)
         @(posedge clock);
      repeat (ROOT_W + 8) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

### filelist.f
sv/dtw_pkg.sv
sv/dtw_ram.sv
sv/dtw_ctrl.sv
sv/dtw_datapath.sv
sv/dtw_distance_engine.sv
sv/dtw_checker.sv
bench/tb_dtw_distance_engine.sv
